// ----- hdl/vpq_pkg.sv -----
package vpq_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int CFG_RESET        = 4096;
    localparam int MIN_LEN          = 16;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 12;
    localparam int CFG_W  = 13;
    localparam int TICK_W = 32;

    localparam logic [OP_W-1:0] OP_RESERVE   = 3'd0;
    localparam logic [OP_W-1:0] OP_COMMIT    = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL    = 3'd2;
    localparam logic [OP_W-1:0] OP_STORE     = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BEGIN = 3'd4;
    localparam logic [OP_W-1:0] OP_POP_END   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ      = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP       = 3'd7;

    localparam logic [BYTE_W-1:0] ST_RESERVED = 8'd1;
    localparam logic [BYTE_W-1:0] ST_READY    = 8'd2;
    localparam logic [BYTE_W-1:0] ST_DELETED  = 8'd3;
    localparam logic [BYTE_W-1:0] ST_END      = 8'd4;

endpackage

// ----- hdl/variable_packet_ring_queue.sv -----
// Each request passes a decode state, the modulo unit where an offset is needed, then memory states;
// reserve writes up to 8 header bytes, and pop begin walks skipped headers before reading the head.
// Offsets beyond the ring length are reduced in the shared modulo unit, one quotient bit per cycle.
// One request at a time through the single-port byte memory.
// Synchronous active-low reset clears offsets, ring length (to 4096, capped at BUFFER_BYTES) and handshake state;
// ring memory contents are not cleared.
module variable_packet_ring_queue #(
    parameter int BUFFER_BYTES = vpq_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = vpq_pkg::HEADER_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [vpq_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vpq_pkg::OP_W-1:0]    s_operation,
    input  logic [vpq_pkg::BYTE_W-1:0]  s_packet_size,
    input  logic [vpq_pkg::BYTE_W-1:0]  s_source_interface,
    input  logic [vpq_pkg::IDX_W-1:0]   s_packet_index,
    input  logic [vpq_pkg::BYTE_W-1:0]  s_byte_index,
    input  logic [vpq_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic [vpq_pkg::TICK_W-1:0]  s_tick,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_index_valid,
    output logic [vpq_pkg::IDX_W-1:0]   m_result_index,
    output logic [vpq_pkg::BYTE_W-1:0]  m_head_size,
    output logic [vpq_pkg::BYTE_W-1:0]  m_head_interface,
    output logic [vpq_pkg::TICK_W-1:0]  m_head_timestamp,
    output logic [vpq_pkg::BYTE_W-1:0]  m_read_data,
    output logic                        m_notify
);
    import vpq_pkg::*;

    localparam int ADDR_W   = $clog2(BUFFER_BYTES);
    localparam int LEN_W    = $clog2(BUFFER_BYTES + 1);
    localparam int OFF_MAX  = (BUFFER_BYTES - 1 > 4095) ? BUFFER_BYTES - 1 : 4095;
    localparam int BASE_MAX = OFF_MAX + HEADER_BYTES + 256;
    localparam int BASE_W   = $clog2(BASE_MAX + 1);
    localparam int Q_W      = BASE_W - 4;
    localparam int KW       = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam int MW       = LEN_W + Q_W;
    localparam int VW       = LEN_W + 1;
    localparam int NW       = (HEADER_BYTES < 8) ? HEADER_BYTES : 8;
    localparam int RESET_LEN = (CFG_RESET > BUFFER_BYTES) ? BUFFER_BYTES : CFG_RESET;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_DECIDE = 15'b000000000000010,
        S_MOD    = 15'b000000000000100,
        S_WEND   = 15'b000000000001000,
        S_WHDR   = 15'b000000000010000,
        S_WONE   = 15'b000000000100000,
        S_RONE   = 15'b000000001000000,
        S_RDAT   = 15'b000000010000000,
        S_PCHK   = 15'b000000100000000,
        S_PST    = 15'b000001000000000,
        S_PSTW   = 15'b000010000000000,
        S_PADV   = 15'b000100000000000,
        S_PHDR   = 15'b001000000000000,
        S_ESZ    = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [ADDR_W-1:0] wr_off_reg, wr_off_next;
    logic [ADDR_W-1:0] rd_off_reg, rd_off_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              m_valid_reg, m_valid_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [BYTE_W-1:0] psize_reg, psize_next;
    logic [BYTE_W-1:0] intf_reg, intf_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [BYTE_W-1:0] bidx_reg, bidx_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [TICK_W-1:0] tick_reg, tick_next;

    logic [BASE_W-1:0] rem_reg, rem_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] at_reg, at_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [VW-1:0]     visit_reg, visit_next;
    logic              found_reg, found_next;
    logic [BYTE_W-1:0] wdata_reg, wdata_next;

    logic              res_idx_valid_reg, res_idx_valid_next;
    logic [IDX_W-1:0]  res_index_reg, res_index_next;
    logic [BYTE_W-1:0] res_size_reg, res_size_next;
    logic [BYTE_W-1:0] res_intf_reg, res_intf_next;
    logic [TICK_W-1:0] res_tick_reg, res_tick_next;
    logic [BYTE_W-1:0] res_rdata_reg, res_rdata_next;
    logic              res_notify_reg, res_notify_next;

    logic              out_idx_valid_reg, out_idx_valid_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [BYTE_W-1:0] out_size_reg, out_size_next;
    logic [BYTE_W-1:0] out_intf_reg, out_intf_next;
    logic [TICK_W-1:0] out_tick_reg, out_tick_next;
    logic [BYTE_W-1:0] out_rdata_reg, out_rdata_next;
    logic              out_notify_reg, out_notify_next;

    logic [BYTE_W-1:0] ring_mem [BUFFER_BYTES];
    logic [BYTE_W-1:0] mem_q_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    logic [BASE_W-1:0] len_b, wr_b, rd_b, total_b, hdr_b, wr_eff_b, adv_b;
    logic [ADDR_W-1:0] addr_inc;
    logic [MW-1:0]     mod_div;
    logic              rsv_fit, rsv_wrap, rsv_fit2, load_out;
    int unsigned       cfg_val;

    assign len_b    = BASE_W'(len_reg);
    assign wr_b     = BASE_W'(wr_off_reg);
    assign rd_b     = BASE_W'(rd_off_reg);
    assign hdr_b    = BASE_W'(HEADER_BYTES);
    assign total_b  = hdr_b + BASE_W'(psize_reg);
    assign rsv_wrap = (rd_off_reg <= wr_off_reg);
    assign rsv_fit  = rsv_wrap && ((wr_b + total_b) < len_b);
    assign wr_eff_b = rsv_wrap ? '0 : wr_b;
    assign rsv_fit2 = (wr_eff_b + total_b + BASE_W'(1)) < rd_b;
    assign adv_b    = rd_b + hdr_b + BASE_W'(mem_q_reg);
    assign addr_inc = ((BASE_W'(addr_reg) + BASE_W'(1)) == len_b) ? '0 : addr_reg + ADDR_W'(1);
    assign mod_div  = MW'(len_reg) << k_reg;
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign cfg_val  = 32'(cfg_wr_data);

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_index_valid    = out_idx_valid_reg;
    assign m_result_index   = out_index_reg;
    assign m_head_size      = out_size_reg;
    assign m_head_interface = out_intf_reg;
    assign m_head_timestamp = out_tick_reg;
    assign m_read_data      = out_rdata_reg;
    assign m_notify         = out_notify_reg;

    always_comb begin
        if (cfg_val < MIN_LEN) begin
            len_next = LEN_W'(MIN_LEN);
        end else if (cfg_val > BUFFER_BYTES) begin
            len_next = LEN_W'(BUFFER_BYTES);
        end else begin
            len_next = LEN_W'(cfg_wr_data);
        end
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        wr_off_next = wr_off_reg;
        rd_off_next = rd_off_reg;
        op_next     = op_reg;
        psize_next  = psize_reg;
        intf_next   = intf_reg;
        pidx_next   = pidx_reg;
        bidx_next   = bidx_reg;
        data_next   = data_reg;
        tick_next   = tick_reg;
        rem_next    = rem_reg;
        k_next      = k_reg;
        addr_next   = addr_reg;
        at_next     = at_reg;
        cnt_next    = cnt_reg;
        visit_next  = visit_reg;
        found_next  = found_reg;
        wdata_next  = wdata_reg;
        res_idx_valid_next = res_idx_valid_reg;
        res_index_next     = res_index_reg;
        res_size_next      = res_size_reg;
        res_intf_next      = res_intf_reg;
        res_tick_next      = res_tick_reg;
        res_rdata_next     = res_rdata_reg;
        res_notify_next    = res_notify_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = wdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    psize_next = s_packet_size;
                    intf_next  = s_source_interface;
                    pidx_next  = s_packet_index;
                    bidx_next  = s_byte_index;
                    data_next  = s_data_byte;
                    tick_next  = s_tick;
                    visit_next = '0;
                    res_idx_valid_next = 1'b0;
                    res_index_next     = '0;
                    res_size_next      = '0;
                    res_intf_next      = '0;
                    res_tick_next      = '0;
                    res_rdata_next     = '0;
                    res_notify_next    = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                k_next = KW'(Q_W - 1);
                unique case (op_reg)
                    OP_RESERVE: begin
                        found_next = rsv_fit || rsv_fit2;
                        at_next    = rsv_fit ? wr_off_reg : ADDR_W'(wr_eff_b);
                        cnt_next   = '0;
                        if (rsv_fit) begin
                            wr_off_next = ADDR_W'(wr_b + total_b);
                        end else if (rsv_fit2) begin
                            wr_off_next = ADDR_W'(wr_eff_b + total_b);
                        end else begin
                            wr_off_next = ADDR_W'(wr_eff_b);
                        end
                        if (!rsv_fit && rsv_wrap) begin
                            wdata_next = ST_END;
                            rem_next   = wr_b;
                            ret_next   = S_WEND;
                            state_next = S_MOD;
                        end else if (rsv_fit || rsv_fit2) begin
                            rem_next   = rsv_fit ? wr_b : wr_eff_b;
                            ret_next   = S_WHDR;
                            state_next = S_MOD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_COMMIT, OP_CANCEL: begin
                        wdata_next      = (op_reg == OP_COMMIT) ? ST_READY : ST_DELETED;
                        res_notify_next = 1'b1;
                        rem_next        = BASE_W'(pidx_reg);
                        ret_next        = S_WONE;
                        state_next      = S_MOD;
                    end
                    OP_STORE: begin
                        wdata_next = data_reg;
                        rem_next   = BASE_W'(pidx_reg) + hdr_b + BASE_W'(bidx_reg);
                        ret_next   = S_WONE;
                        state_next = S_MOD;
                    end
                    OP_READ: begin
                        rem_next   = BASE_W'(pidx_reg) + hdr_b + BASE_W'(bidx_reg);
                        ret_next   = S_RONE;
                        state_next = S_MOD;
                    end
                    OP_POP_BEGIN: begin
                        state_next = S_PCHK;
                    end
                    OP_POP_END: begin
                        res_notify_next = 1'b1;
                        if (rd_off_reg != wr_off_reg) begin
                            rem_next   = rd_b;
                            ret_next   = S_ESZ;
                            state_next = S_MOD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_NOP: begin
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MOD: begin
                if (rem_reg < len_b) begin
                    addr_next  = ADDR_W'(rem_reg);
                    state_next = ret_reg;
                end else begin
                    if (MW'(rem_reg) >= mod_div) begin
                        rem_next = rem_reg - BASE_W'(mod_div);
                    end
                    if (k_reg != '0) begin
                        k_next = k_reg - KW'(1);
                    end
                end
            end
            S_WEND: begin
                mem_we = 1'b1;
                if (found_reg) begin
                    addr_next  = '0;
                    state_next = S_WHDR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_WHDR: begin
                mem_we = 1'b1;
                case (cnt_reg)
                    3'd0: mem_wdata = ST_RESERVED;
                    3'd1: mem_wdata = psize_reg;
                    3'd2: mem_wdata = intf_reg;
                    3'd3: mem_wdata = '0;
                    3'd4: mem_wdata = tick_reg[7:0];
                    3'd5: mem_wdata = tick_reg[15:8];
                    3'd6: mem_wdata = tick_reg[23:16];
                    default: mem_wdata = tick_reg[31:24];
                endcase
                addr_next = addr_inc;
                if (cnt_reg == 3'(NW - 1)) begin
                    res_idx_valid_next = 1'b1;
                    res_index_next     = IDX_W'(at_reg);
                    state_next         = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_WONE: begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_RONE: begin
                mem_re     = 1'b1;
                state_next = S_RDAT;
            end
            S_RDAT: begin
                res_rdata_next = mem_q_reg;
                state_next     = S_DONE;
            end
            S_PCHK: begin
                k_next = KW'(Q_W - 1);
                if (visit_reg == (VW'(len_reg) + VW'(1)) || rd_off_reg == wr_off_reg) begin
                    state_next = S_DONE;
                end else begin
                    visit_next = visit_reg + VW'(1);
                    rem_next   = rd_b;
                    ret_next   = S_PST;
                    state_next = S_MOD;
                end
            end
            S_PST: begin
                mem_re     = 1'b1;
                addr_next  = addr_inc;
                state_next = S_PSTW;
            end
            S_PSTW: begin
                mem_re    = 1'b1;
                addr_next = addr_inc;
                cnt_next  = 3'd1;
                if (mem_q_reg == ST_END) begin
                    rd_off_next = '0;
                    state_next  = S_PCHK;
                end else if (mem_q_reg == ST_DELETED) begin
                    state_next = S_PADV;
                end else begin
                    res_idx_valid_next = 1'b1;
                    res_index_next     = IDX_W'(rd_off_reg);
                    state_next         = S_PHDR;
                end
            end
            S_PADV: begin
                if (adv_b < len_b) begin
                    rd_off_next = ADDR_W'(adv_b);
                end else begin
                    rd_off_next = '0;
                end
                state_next = (op_reg == OP_POP_BEGIN) ? S_PCHK : S_DONE;
            end
            S_PHDR: begin
                case (cnt_reg)
                    3'd1: res_size_next = mem_q_reg;
                    3'd2: res_intf_next = mem_q_reg;
                    3'd4: res_tick_next[7:0]   = mem_q_reg;
                    3'd5: res_tick_next[15:8]  = mem_q_reg;
                    3'd6: res_tick_next[23:16] = mem_q_reg;
                    3'd7: res_tick_next[31:24] = mem_q_reg;
                    default: ;
                endcase
                if (cnt_reg == 3'(NW - 1)) begin
                    state_next = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    addr_next = addr_inc;
                    cnt_next  = cnt_reg + 3'd1;
                end
            end
            S_ESZ: begin
                mem_re     = 1'b1;
                mem_addr   = addr_inc;
                state_next = S_PADV;
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_idx_valid_next = out_idx_valid_reg;
        out_index_next     = out_index_reg;
        out_size_next      = out_size_reg;
        out_intf_next      = out_intf_reg;
        out_tick_next      = out_tick_reg;
        out_rdata_next     = out_rdata_reg;
        out_notify_next    = out_notify_reg;
        m_valid_next       = m_valid_reg;
        if (load_out) begin
            out_idx_valid_next = res_idx_valid_reg;
            out_index_next     = res_index_reg;
            out_size_next      = res_size_reg;
            out_intf_next      = res_intf_reg;
            out_tick_next      = res_tick_reg;
            out_rdata_next     = res_rdata_reg;
            out_notify_next    = res_notify_reg;
            m_valid_next       = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            wr_off_reg  <= '0;
            rd_off_reg  <= '0;
            len_reg     <= LEN_W'(RESET_LEN);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            wr_off_reg  <= wr_off_next;
            rd_off_reg  <= rd_off_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        psize_reg  <= psize_next;
        intf_reg   <= intf_next;
        pidx_reg   <= pidx_next;
        bidx_reg   <= bidx_next;
        data_reg   <= data_next;
        tick_reg   <= tick_next;
        rem_reg    <= rem_next;
        k_reg      <= k_next;
        addr_reg   <= addr_next;
        at_reg     <= at_next;
        cnt_reg    <= cnt_next;
        visit_reg  <= visit_next;
        found_reg  <= found_next;
        wdata_reg  <= wdata_next;
        res_idx_valid_reg <= res_idx_valid_next;
        res_index_reg     <= res_index_next;
        res_size_reg      <= res_size_next;
        res_intf_reg      <= res_intf_next;
        res_tick_reg      <= res_tick_next;
        res_rdata_reg     <= res_rdata_next;
        res_notify_reg    <= res_notify_next;
        out_idx_valid_reg <= out_idx_valid_next;
        out_index_reg     <= out_index_next;
        out_size_reg      <= out_size_next;
        out_intf_reg      <= out_intf_next;
        out_tick_reg      <= out_tick_next;
        out_rdata_reg     <= out_rdata_next;
        out_notify_reg    <= out_notify_next;
    end

    // single-port byte ring, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= ring_mem[mem_addr];
        end
    end

    a_mem_addr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we || mem_re) |-> (BASE_W'(mem_addr) < len_b))
        else $error("ring access beyond ring length");

    a_mod_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD) |-> ((MW + 1)'(rem_reg) < ((MW + 1)'(mod_div) << 1)))
        else $error("modulo remainder out of range");

    a_visit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PCHK) |-> (visit_reg <= (VW'(len_reg) + VW'(1))))
        else $error("pop walk exceeded visit limit");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after completion");

    a_notify_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_notify_reg && out_idx_valid_reg))
        else $error("notify and index valid both set");

endmodule

// ----- sim/variable_packet_ring_queue_tb.sv -----
`timescale 1ns / 100ps

module variable_packet_ring_queue_tb;

    import vpq_pkg::*;

    localparam int HDR            = HEADER_BYTES_DEF;
    localparam int RING_MAX       = BUFFER_BYTES_DEF;
    localparam int TICK_AT        = 4;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 150;
    localparam int PHASE_ITEMS    = 85;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] packet_size;
        logic [BYTE_W-1:0] source_interface;
        logic [IDX_W-1:0]  packet_index;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] data_byte;
        logic [TICK_W-1:0] tick;
    } queue_request_t;

    typedef struct packed {
        logic              index_valid;
        logic [IDX_W-1:0]  result_index;
        logic [BYTE_W-1:0] head_size;
        logic [BYTE_W-1:0] head_interface;
        logic [TICK_W-1:0] head_timestamp;
        logic [BYTE_W-1:0] read_data;
        logic              notify;
    } queue_result_t;

    typedef struct packed {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_value;
        bit               typed;
        queue_request_t   rq;
        queue_result_t    res;
    } directed_step_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [BYTE_W-1:0]   s_packet_size;
    logic [BYTE_W-1:0]   s_source_interface;
    logic [IDX_W-1:0]    s_packet_index;
    logic [BYTE_W-1:0]   s_byte_index;
    logic [BYTE_W-1:0]   s_data_byte;
    logic [TICK_W-1:0]   s_tick;
    logic                m_valid;
    logic                m_ready;
    logic                m_index_valid;
    logic [IDX_W-1:0]    m_result_index;
    logic [BYTE_W-1:0]   m_head_size;
    logic [BYTE_W-1:0]   m_head_interface;
    logic [TICK_W-1:0]   m_head_timestamp;
    logic [BYTE_W-1:0]   m_read_data;
    logic                m_notify;

    // shadow of the ring
    logic [BYTE_W-1:0]   shadow_ring [RING_MAX];
    bit                  shadow_written [RING_MAX];
    int unsigned         shadow_wr;
    int unsigned         shadow_rd;
    logic [CFG_W-1:0]    shadow_cfg;
    bit                  hit_blank;
    int unsigned         blank_slot;

    queue_result_t       predicted_answers [$];
    directed_step_t      directed_steps [$];
    int unsigned         accepted_requests;
    int unsigned         error_count;
    int unsigned         idle_cycles;
    bit                  quiet_tail;
    bit                  long_hold_done;

    variable_packet_ring_queue i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_packet_size      (s_packet_size),
        .s_source_interface (s_source_interface),
        .s_packet_index     (s_packet_index),
        .s_byte_index       (s_byte_index),
        .s_data_byte        (s_data_byte),
        .s_tick             (s_tick),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_index_valid      (m_index_valid),
        .m_result_index     (m_result_index),
        .m_head_size        (m_head_size),
        .m_head_interface   (m_head_interface),
        .m_head_timestamp   (m_head_timestamp),
        .m_read_data        (m_read_data),
        .m_notify           (m_notify)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned ring_length();
        int unsigned n;
        n = shadow_cfg;
        if (n > RING_MAX) n = RING_MAX;
        if (n < MIN_LEN) n = MIN_LEN;
        return n;
    endfunction

    // flags the first never-written byte touched by a request
    function automatic logic [BYTE_W-1:0] ring_peek(int unsigned addr);
        int unsigned slot;
        slot = addr % ring_length();
        if (!shadow_written[slot]) begin
            if (!hit_blank) begin
                hit_blank  = 1'b1;
                blank_slot = slot;
            end
            return '0;
        end
        return shadow_ring[slot];
    endfunction

    function automatic void ring_poke(int unsigned addr, logic [BYTE_W-1:0] value);
        int unsigned slot;
        slot = addr % ring_length();
        shadow_ring[slot]    = value;
        shadow_written[slot] = 1'b1;
    endfunction

    function automatic void skip_packet();
        int unsigned span;
        span = HDR + ring_peek(shadow_rd + 1);
        if (shadow_rd + span < ring_length()) shadow_rd += span;
        else shadow_rd = 0;
    endfunction

    function automatic queue_result_t apply_request(queue_request_t rq);
        queue_result_t r;
        int unsigned   len;
        int unsigned   span;
        int unsigned   at;
        int unsigned   visits;
        logic [7:0]    status;
        bit            placed;
        r    = '0;
        len  = ring_length();
        span = HDR + rq.packet_size;
        case (rq.op)
            OP_RESERVE: begin
                placed = 1'b0;
                at     = 0;
                if (shadow_rd <= shadow_wr && shadow_wr + span < len) begin
                    at        = shadow_wr;
                    shadow_wr = shadow_wr + span;
                    placed    = 1'b1;
                end else begin
                    // no room at the end: mark it and wrap
                    if (shadow_rd <= shadow_wr) begin
                        ring_poke(shadow_wr, ST_END);
                        shadow_wr = 0;
                    end
                    if (shadow_wr + span + 1 < shadow_rd) begin
                        at        = shadow_wr;
                        shadow_wr = shadow_wr + span;
                        placed    = 1'b1;
                    end
                end
                if (placed) begin
                    ring_poke(at, ST_RESERVED);
                    ring_poke(at + 1, rq.packet_size);
                    ring_poke(at + 2, rq.source_interface);
                    ring_poke(at + 3, '0);
                    for (int k = 0; k < 4; k++) ring_poke(at + TICK_AT + k, rq.tick[8*k +: 8]);
                    r.index_valid  = 1'b1;
                    r.result_index = at[IDX_W-1:0];
                end
            end
            OP_COMMIT: begin
                ring_poke(rq.packet_index, ST_READY);
                r.notify = 1'b1;
            end
            OP_CANCEL: begin
                ring_poke(rq.packet_index, ST_DELETED);
                r.notify = 1'b1;
            end
            OP_STORE: begin
                ring_poke(rq.packet_index + HDR + rq.byte_index, rq.data_byte);
            end
            OP_POP_BEGIN: begin
                for (visits = 0; visits <= len; visits++) begin
                    if (shadow_rd == shadow_wr) break;
                    status = ring_peek(shadow_rd);
                    if (status == ST_END) begin
                        shadow_rd = 0;
                    end else if (status == ST_DELETED) begin
                        skip_packet();
                    end else begin
                        r.index_valid    = 1'b1;
                        r.result_index   = shadow_rd[IDX_W-1:0];
                        r.head_size      = ring_peek(shadow_rd + 1);
                        r.head_interface = ring_peek(shadow_rd + 2);
                        for (int k = 0; k < 4; k++) begin
                            r.head_timestamp[8*k +: 8] = ring_peek(shadow_rd + TICK_AT + k);
                        end
                        break;
                    end
                end
            end
            OP_POP_END: begin
                if (shadow_rd != shadow_wr) skip_packet();
                r.notify = 1'b1;
            end
            OP_READ: begin
                r.read_data = ring_peek(rq.packet_index + HDR + rq.byte_index);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic queue_request_t request_of(logic [OP_W-1:0] op, logic [7:0] psize,
                                                  logic [7:0] intf, logic [IDX_W-1:0] pidx,
                                                  logic [7:0] bidx, logic [7:0] data,
                                                  logic [TICK_W-1:0] tick);
        queue_request_t rq;
        rq.op               = op;
        rq.packet_size      = psize;
        rq.source_interface = intf;
        rq.packet_index     = pidx;
        rq.byte_index       = bidx;
        rq.data_byte        = data;
        rq.tick             = tick;
        return rq;
    endfunction

    function automatic queue_request_t random_request();
        return request_of(OP_W'($urandom_range(0, 7)), BYTE_W'($urandom), BYTE_W'($urandom),
                          IDX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), $urandom);
    endfunction

    function automatic queue_result_t answer_of(logic iv, logic [IDX_W-1:0] idx,
                                                logic [7:0] hsize, logic [7:0] hintf,
                                                logic [TICK_W-1:0] ts, logic [7:0] rdata,
                                                logic notify);
        queue_result_t r;
        r.index_valid    = iv;
        r.result_index   = idx;
        r.head_size      = hsize;
        r.head_interface = hintf;
        r.head_timestamp = ts;
        r.read_data      = rdata;
        r.notify         = notify;
        return r;
    endfunction

    function automatic directed_step_t typed_row(queue_request_t rq, queue_result_t res);
        directed_step_t s;
        s       = '0;
        s.typed = 1'b1;
        s.rq    = rq;
        s.res   = res;
        return s;
    endfunction

    function automatic directed_step_t plain_row(queue_request_t rq);
        directed_step_t s;
        s    = '0;
        s.rq = rq;
        return s;
    endfunction

    function automatic directed_step_t size_row(logic [CFG_W-1:0] value);
        directed_step_t s;
        s           = '0;
        s.is_cfg    = 1'b1;
        s.cfg_value = value;
        return s;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            error_count++;
        end
    endfunction

    // A request that would touch a never-written byte is swapped for a
    // commit or cancel that writes that byte first.
    task automatic send_request(input queue_request_t rq, input bit typed,
                                input queue_result_t typed_res, output queue_result_t got);
        int unsigned rd_keep;
        rd_keep   = shadow_rd;
        hit_blank = 1'b0;
        got       = apply_request(rq);
        if (hit_blank) begin
            shadow_rd       = rd_keep;
            rq.op           = $urandom_range(0, 1) ? OP_COMMIT : OP_CANCEL;
            rq.packet_index = IDX_W'(blank_slot);
            got             = apply_request(rq);
        end
        predicted_answers.push_back(typed ? typed_res : got);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_operation        <= rq.op;
        s_packet_size      <= rq.packet_size;
        s_source_interface <= rq.source_interface;
        s_packet_index     <= rq.packet_index;
        s_byte_index       <= rq.byte_index;
        s_data_byte        <= rq.data_byte;
        s_tick             <= rq.tick;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (predicted_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_ring_size(input logic [CFG_W-1:0] value);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_cfg   = value;
    endtask

    task automatic run_traffic(input int unsigned count);
        queue_request_t   rq;
        queue_result_t    got;
        int unsigned      issued;
        int unsigned      psize;
        int unsigned      n;
        logic [IDX_W-1:0] base;
        issued = 0;
        while (issued < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // producer: reserve, fill part of the payload, then commit or cancel
                    rq             = random_request();
                    rq.op          = OP_RESERVE;
                    rq.packet_size = ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                                 : BYTE_W'($urandom_range(0, 12));
                    send_request(rq, 1'b0, '0, got);
                    issued++;
                    if (got.index_valid) begin
                        base  = got.result_index;
                        psize = rq.packet_size;
                        n     = (psize == 0) ? 0 : $urandom_range(0, (psize < 4) ? psize : 4);
                        repeat (n) begin
                            rq              = random_request();
                            rq.op           = OP_STORE;
                            rq.packet_index = base;
                            rq.byte_index   = BYTE_W'($urandom_range(0, psize - 1));
                            send_request(rq, 1'b0, '0, got);
                            issued++;
                        end
                        rq              = random_request();
                        rq.op           = ($urandom_range(0, 4) == 0) ? OP_CANCEL : OP_COMMIT;
                        rq.packet_index = base;
                        send_request(rq, 1'b0, '0, got);
                        issued++;
                    end
                end
                4, 5, 6: begin
                    // consumer: find the head, read some payload, release it
                    rq    = random_request();
                    rq.op = OP_POP_BEGIN;
                    send_request(rq, 1'b0, '0, got);
                    issued++;
                    if (got.index_valid) begin
                        base  = got.result_index;
                        psize = got.head_size;
                        n     = (psize == 0) ? 0 : $urandom_range(0, 2);
                        repeat (n) begin
                            rq              = random_request();
                            rq.op           = OP_READ;
                            rq.packet_index = base;
                            rq.byte_index   = BYTE_W'($urandom_range(0, psize - 1));
                            send_request(rq, 1'b0, '0, got);
                            issued++;
                        end
                    end
                    if ($urandom_range(0, 9) != 0) begin
                        rq    = random_request();
                        rq.op = OP_POP_END;
                        send_request(rq, 1'b0, '0, got);
                        issued++;
                    end
                end
                default: begin
                    send_request(random_request(), 1'b0, '0, got);
                    issued++;
                end
            endcase
        end
    endtask

    initial begin
        logic [CFG_W-1:0] ring_settings [7];
        queue_result_t    got;
        aresetn            <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        s_valid            <= 1'b0;
        s_operation        <= OP_NOP;
        s_packet_size      <= '0;
        s_source_interface <= '0;
        s_packet_index     <= '0;
        s_byte_index       <= '0;
        s_data_byte        <= '0;
        s_tick             <= '0;
        shadow_cfg          = CFG_RESET;
        shadow_wr           = 0;
        shadow_rd           = 0;
        quiet_tail          = 1'b0;

        directed_steps.push_back(typed_row(request_of(OP_POP_BEGIN, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_POP_END, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        directed_steps.push_back(typed_row(request_of(OP_NOP, 255, 255, 4095, 255, 255,
                                                      32'hFFFF_FFFF),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_RESERVE, 0, 0, 0, 0, 0, 0),
                                           answer_of(1, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_RESERVE, 255, 255, 0, 0, 0,
                                                      32'hFFFF_FFFF),
                                           answer_of(1, 8, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_STORE, 0, 0, 8, 0, 8'hA5, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_STORE, 0, 0, 8, 255, 8'hFF, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_READ, 0, 0, 8, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 8'hA5, 0)));
        directed_steps.push_back(typed_row(request_of(OP_READ, 0, 0, 8, 255, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 8'hFF, 0)));
        directed_steps.push_back(typed_row(request_of(OP_COMMIT, 0, 0, 8, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        directed_steps.push_back(typed_row(request_of(OP_CANCEL, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        directed_steps.push_back(typed_row(request_of(OP_POP_BEGIN, 0, 0, 0, 0, 0, 0),
                                           answer_of(1, 8, 255, 255, 32'hFFFF_FFFF, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_POP_END, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        directed_steps.push_back(typed_row(request_of(OP_POP_BEGIN, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        // byte address past the ring end wraps around
        directed_steps.push_back(typed_row(request_of(OP_STORE, 0, 0, 4095, 255, 8'h3C, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_READ, 0, 0, 4095, 255, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 8'h3C, 0)));
        directed_steps.push_back(typed_row(request_of(OP_COMMIT, 0, 0, 4095, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        // smallest ring, offsets left beyond it
        directed_steps.push_back(size_row(CFG_W'(MIN_LEN)));
        directed_steps.push_back(plain_row(request_of(OP_RESERVE, 0, 1, 0, 0, 0, 32'h0102_0304)));
        directed_steps.push_back(typed_row(request_of(OP_CANCEL, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        // deleted header spanning the whole ring: skip walk only stops at the visit limit
        directed_steps.push_back(typed_row(request_of(OP_STORE, 0, 0, 0, 9, 8, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(plain_row(request_of(OP_POP_BEGIN, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(typed_row(request_of(OP_COMMIT, 0, 0, 0, 0, 0, 0),
                                           answer_of(0, 0, 0, 0, 0, 0, 1)));
        directed_steps.push_back(plain_row(request_of(OP_POP_BEGIN, 0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(plain_row(request_of(OP_POP_END, 0, 0, 0, 0, 0, 0)));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                write_ring_size(directed_steps[i].cfg_value);
            end else begin
                send_request(directed_steps[i].rq, directed_steps[i].typed,
                             directed_steps[i].res, got);
            end
        end

        ring_settings = '{13'd8191, 13'd0, 13'd40, CFG_W'($urandom_range(16, 300)), 13'd4096,
                          CFG_W'($urandom_range(16, 4096)), 13'd4096};
        foreach (ring_settings[p]) begin
            write_ring_size(ring_settings[p]);
            if (p == 6) quiet_tail = 1'b1;
            run_traffic(PHASE_ITEMS);
        end

        settle_idle();
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        m_ready        <= 1'b0;
        long_hold_done  = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && accepted_requests >= HOLD_AFTER) begin
                // hold results back long enough for the input side to stall
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        accepted_requests = 0;
        error_count       = 0;
        idle_cycles       = 0;
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) accepted_requests++;
            if (m_valid && m_ready) begin
                if (predicted_answers.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    error_count++;
                end else begin
                    want = predicted_answers.pop_front();
                    check_field("index_valid", want.index_valid, m_index_valid);
                    check_field("result_index", want.result_index, m_result_index);
                    check_field("head_size", want.head_size, m_head_size);
                    check_field("head_interface", want.head_interface, m_head_interface);
                    check_field("head_timestamp", want.head_timestamp, m_head_timestamp);
                    check_field("read_data", want.read_data, m_read_data);
                    check_field("notify", want.notify, m_notify);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
